/* sv/cls_pkg.sv */
// Shared types, widths, register indexes and the arctangent table of the steering block.
`default_nettype none
package cls_pkg;

    localparam int SUM_W = 34;
    localparam int AW    = 36;
    localparam int ZW    = 26;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_WEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_WEIGHT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_GAIN      = 3'd5;

    localparam logic signed [SUM_W-1:0] NEAR_ZERO   = 34'sd269;
    localparam logic signed [ZW-1:0]    DEG180_Q16  = 26'sd11796480;
    localparam logic signed [18:0]      HEADING_MAX = 19'sd46080;

    typedef struct packed {
        logic signed [10:0] target_position;
        logic [9:0]         error_limit;
        logic [14:0]        second_weight;
        logic [14:0]        third_weight;
        logic [16:0]        position_gain;
        logic [16:0]        angle_gain;
    } t_cfg;

    typedef struct packed {
        logic               near_zero;
        logic signed [10:0] err;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_q16(input int unsigned idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:       v = 26'sd2949120;
            1:       v = 26'sd1740967;
            2:       v = 26'sd919879;
            3:       v = 26'sd466945;
            4:       v = 26'sd234379;
            5:       v = 26'sd117304;
            6:       v = 26'sd58666;
            7:       v = 26'sd29335;
            8:       v = 26'sd14668;
            9:       v = 26'sd7334;
            10:      v = 26'sd3667;
            11:      v = 26'sd1833;
            12:      v = 26'sd917;
            13:      v = 26'sd458;
            14:      v = 26'sd229;
            15:      v = 26'sd115;
            16:      v = 26'sd57;
            17:      v = 26'sd29;
            18:      v = 26'sd14;
            19:      v = 26'sd7;
            20:      v = 26'sd4;
            21:      v = 26'sd2;
            22:      v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* sv/cls_vec_sum.sv */
// Weighted direction sum, error clamp and CORDIC pre-rotation, three register stages.
`default_nettype none
module cls_vec_sum (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  cls_pkg::t_cfg                    i_cfg,
    input  wire signed [10:0]                i_start_x,
    input  wire signed [15:0]                i_px,
    input  wire signed [15:0]                i_py,
    input  wire signed [15:0]                i_qx,
    input  wire signed [15:0]                i_qy,
    input  wire signed [15:0]                i_rx,
    input  wire signed [15:0]                i_ry,
    output logic                             o_valid,
    output logic signed [cls_pkg::AW-1:0]    o_a,
    output logic signed [cls_pkg::AW-1:0]    o_b,
    output logic signed [cls_pkg::ZW-1:0]    o_z,
    output cls_pkg::t_side                   o_side
);

    logic [2:0] r_v;

    logic signed [15:0] r_px, r_py;
    logic signed [31:0] r_qx, r_qy, r_rx, r_ry;
    logic signed [10:0] r_err1, r_err2;
    logic signed [31:0] n_qx, n_qy, n_rx, n_ry;
    logic signed [11:0] w_err, w_lim;
    logic signed [10:0] n_err;

    logic signed [cls_pkg::SUM_W-1:0] r_sx, r_sy, n_sx, n_sy;

    logic signed [cls_pkg::AW-1:0] r_a, r_b, n_a, n_b;
    logic signed [cls_pkg::ZW-1:0] r_z, n_z;
    cls_pkg::t_side r_side, n_side;

    always_comb begin
        n_qx  = i_qx * $signed({1'b0, i_cfg.second_weight});
        n_qy  = i_qy * $signed({1'b0, i_cfg.second_weight});
        n_rx  = i_rx * $signed({1'b0, i_cfg.third_weight});
        n_ry  = i_ry * $signed({1'b0, i_cfg.third_weight});
        w_err = 12'(i_cfg.target_position) - 12'(i_start_x);
        w_lim = $signed({2'b00, i_cfg.error_limit});
        if (w_err > w_lim) begin
            n_err = w_lim[10:0];
        end else if (w_err < -w_lim) begin
            n_err = 11'(-w_lim);
        end else begin
            n_err = w_err[10:0];
        end
    end

    always_comb begin
        n_sx = (cls_pkg::SUM_W'(r_px) <<< 14) + cls_pkg::SUM_W'(r_qx)
             + cls_pkg::SUM_W'(r_rx);
        n_sy = (cls_pkg::SUM_W'(r_py) <<< 14) + cls_pkg::SUM_W'(r_qy)
             + cls_pkg::SUM_W'(r_ry);
    end

    always_comb begin
        n_side.err       = r_err2;
        n_side.near_zero = (r_sx < cls_pkg::NEAR_ZERO) && (r_sx > -cls_pkg::NEAR_ZERO)
                        && (r_sy < cls_pkg::NEAR_ZERO) && (r_sy > -cls_pkg::NEAR_ZERO);
        if (r_sy < 0) begin
            n_a = -cls_pkg::AW'(r_sy);
            n_b = -cls_pkg::AW'(r_sx);
            n_z = (r_sx >= 0) ? cls_pkg::DEG180_Q16 : -cls_pkg::DEG180_Q16;
        end else begin
            n_a = cls_pkg::AW'(r_sy);
            n_b = cls_pkg::AW'(r_sx);
            n_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px   <= i_px;
            r_py   <= i_py;
            r_qx   <= n_qx;
            r_qy   <= n_qy;
            r_rx   <= n_rx;
            r_ry   <= n_ry;
            r_err1 <= n_err;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_err2 <= r_err1;
            r_a    <= n_a;
            r_b    <= n_b;
            r_z    <= n_z;
            r_side <= n_side;
        end
    end

    assign o_valid = r_v[2];
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule
`default_nettype wire

/* sv/cls_cordic.sv */
// Vectoring CORDIC pipeline, one micro-rotation per register stage.
`default_nettype none
module cls_cordic #(
    parameter int STEPS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire signed [cls_pkg::AW-1:0]     i_a,
    input  wire signed [cls_pkg::AW-1:0]     i_b,
    input  wire signed [cls_pkg::ZW-1:0]     i_z,
    input  cls_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic signed [cls_pkg::ZW-1:0]    o_z,
    output cls_pkg::t_side                   o_side
);

    logic signed [cls_pkg::AW-1:0] w_a [0:STEPS-1];
    logic signed [cls_pkg::AW-1:0] w_b [0:STEPS-1];
    logic signed [cls_pkg::ZW-1:0] w_z [0:STEPS];
    cls_pkg::t_side                w_side [0:STEPS];
    logic [STEPS:0]                w_v;

    assign w_a[0]    = i_a;
    assign w_b[0]    = i_b;
    assign w_z[0]    = i_z;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_valid;

    for (genvar i = 0; i < STEPS; i++) begin : g_stage
        logic signed [cls_pkg::AW-1:0] n_a, n_b;
        logic signed [cls_pkg::ZW-1:0] n_z, r_z;
        cls_pkg::t_side                r_side;
        logic                          r_v;

        always_comb begin
            if (w_b[i] > 0) begin
                n_a = w_a[i] + (w_b[i] >>> i);
                n_b = w_b[i] - (w_a[i] >>> i);
                n_z = w_z[i] + cls_pkg::atan_q16(i);
            end else begin
                n_a = w_a[i] - (w_b[i] >>> i);
                n_b = w_b[i] + (w_a[i] >>> i);
                n_z = w_z[i] - cls_pkg::atan_q16(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z    <= n_z;
                r_side <= w_side[i];
            end
        end

        assign w_z[i+1]    = r_z;
        assign w_side[i+1] = r_side;
        assign w_v[i+1]    = r_v;

        if (i < STEPS - 1) begin : g_ab
            logic signed [cls_pkg::AW-1:0] r_a, r_b;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a <= n_a;
                    r_b <= n_b;
                end
            end
            assign w_a[i+1] = r_a;
            assign w_b[i+1] = r_b;
        end
    end

    assign o_valid = w_v[STEPS];
    assign o_z     = w_z[STEPS];
    assign o_side  = w_side[STEPS];

endmodule
`default_nettype wire

/* sv/cls_steer_out.sv */
// Heading rounding, gain products and saturated steering sum, three register stages.
`default_nettype none
module cls_steer_out (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  cls_pkg::t_cfg                    i_cfg,
    input  wire signed [cls_pkg::ZW-1:0]     i_z,
    input  cls_pkg::t_side                   i_side,
    output logic                             o_valid,
    output logic signed [15:0]               o_steering,
    output logic signed [10:0]               o_clamped_error,
    output logic signed [16:0]               o_heading_degrees
);

    logic [2:0] r_v;

    logic [cls_pkg::ZW-1:0] w_mag, w_rnd;
    logic signed [18:0]     w_r, w_head;
    logic signed [16:0]     n_head, r_head1, r_head2, r_head3;
    logic signed [10:0]     r_err1, r_err2, r_err3;

    logic signed [28:0] n_pe, r_pe;
    logic signed [34:0] n_ph, r_ph;

    logic signed [37:0] w_acc, w_acc_t, w_q;
    logic signed [15:0] n_steer, r_steer;

    always_comb begin
        w_mag = (i_z < 0) ? cls_pkg::ZW'(-i_z) : cls_pkg::ZW'(i_z);
        w_rnd = w_mag + cls_pkg::ZW'(128);
        w_r   = $signed({1'b0, w_rnd[cls_pkg::ZW-1:8]});
        w_head = (i_z >= 0) ? -w_r : w_r;
        if (i_side.near_zero) begin
            n_head = '0;
        end else if (w_head > cls_pkg::HEADING_MAX) begin
            n_head = cls_pkg::HEADING_MAX[16:0];
        end else if (w_head < -cls_pkg::HEADING_MAX) begin
            n_head = 17'(-cls_pkg::HEADING_MAX);
        end else begin
            n_head = w_head[16:0];
        end
    end

    always_comb begin
        n_pe = r_err1 * $signed({1'b0, i_cfg.position_gain});
        n_ph = r_head1 * $signed({1'b0, i_cfg.angle_gain});
    end

    always_comb begin
        w_acc   = (38'(r_pe) <<< 8) + 38'(r_ph);
        w_acc_t = (w_acc < 0) ? w_acc + 38'sd16777215 : w_acc;
        w_q     = w_acc_t >>> 24;
        if (w_q > 38'sd32767) begin
            n_steer = 16'sh7FFF;
        end else if (w_q < -38'sd32768) begin
            n_steer = 16'sh8000;
        end else begin
            n_steer = w_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_head1 <= n_head;
            r_err1  <= i_side.err;
            r_pe    <= n_pe;
            r_ph    <= n_ph;
            r_head2 <= r_head1;
            r_err2  <= r_err1;
            r_steer <= n_steer;
            r_head3 <= r_head2;
            r_err3  <= r_err2;
        end
    end

    assign o_valid           = r_v[2];
    assign o_steering        = r_steer;
    assign o_clamped_error   = r_err3;
    assign o_heading_degrees = r_head3;

endmodule
`default_nettype wire

/* sv/camera_line_steering.sv */
// Top level of the line steering block: configuration registers and pipeline stitching.
//
//   channel   direction  handshake                       payload
//   s_axis    in         i_s_axis_tvalid/o_s_axis_tready  112-bit line detection item
//   m_axis    out        o_m_axis_tvalid/i_m_axis_tready  48-bit steering item
//   cfg       in         i_cfg_valid/o_cfg_ready          3-bit index, 17-bit data
//
// One item enters per cycle unless m_axis stalls; results pass the vector sum,
// CORDIC (one micro-rotation per stage) and output stages in that order.
// Reset clears the valid bits and loads the register defaults.
// A stall on m_axis freezes every stage, so s_axis ready follows the output side.
`default_nettype none
module camera_line_steering #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // primary_start_x, primary_dir_x, primary_dir_y, second_dir_x, second_dir_y,
    // third_dir_x, third_dir_y, zero pad
    input  wire  [111:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    // steering, clamped_error, heading_degrees, zero pad
    output logic [47:0]  o_m_axis_tdata,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [cls_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [cls_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    cls_pkg::t_cfg r_cfg;
    logic          w_en;

    logic                          v_valid, c_valid, s_valid;
    logic signed [cls_pkg::AW-1:0] v_a, v_b;
    logic signed [cls_pkg::ZW-1:0] v_z, c_z;
    cls_pkg::t_side                v_side, c_side;
    logic signed [15:0]            s_steer;
    logic signed [10:0]            s_err;
    logic signed [16:0]            s_head;

    assign w_en            = !s_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_position <= -11'sd20;
            r_cfg.error_limit     <= 10'd150;
            r_cfg.second_weight   <= 15'd6554;
            r_cfg.third_weight    <= 15'd3277;
            r_cfg.position_gain   <= 17'd4063;
            r_cfg.angle_gain      <= 17'd62915;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                cls_pkg::REG_TARGET_POSITION: r_cfg.target_position <= i_cfg_data[10:0];
                cls_pkg::REG_ERROR_LIMIT:     r_cfg.error_limit     <= i_cfg_data[9:0];
                cls_pkg::REG_SECOND_WEIGHT:   r_cfg.second_weight   <= i_cfg_data[14:0];
                cls_pkg::REG_THIRD_WEIGHT:    r_cfg.third_weight    <= i_cfg_data[14:0];
                cls_pkg::REG_POSITION_GAIN:   r_cfg.position_gain   <= i_cfg_data;
                cls_pkg::REG_ANGLE_GAIN:      r_cfg.angle_gain      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cls_vec_sum u_vec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_s_axis_tvalid),
        .i_cfg     (r_cfg),
        .i_start_x (i_s_axis_tdata[10:0]),
        .i_px      (i_s_axis_tdata[26:11]),
        .i_py      (i_s_axis_tdata[42:27]),
        .i_qx      (i_s_axis_tdata[58:43]),
        .i_qy      (i_s_axis_tdata[74:59]),
        .i_rx      (i_s_axis_tdata[90:75]),
        .i_ry      (i_s_axis_tdata[106:91]),
        .o_valid   (v_valid),
        .o_a       (v_a),
        .o_b       (v_b),
        .o_z       (v_z),
        .o_side    (v_side)
    );

    cls_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (v_valid),
        .i_a     (v_a),
        .i_b     (v_b),
        .i_z     (v_z),
        .i_side  (v_side),
        .o_valid (c_valid),
        .o_z     (c_z),
        .o_side  (c_side)
    );

    cls_steer_out u_steer (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_valid           (c_valid),
        .i_cfg             (r_cfg),
        .i_z               (c_z),
        .i_side            (c_side),
        .o_valid           (s_valid),
        .o_steering        (s_steer),
        .o_clamped_error   (s_err),
        .o_heading_degrees (s_head)
    );

    assign o_m_axis_tvalid = s_valid;
    assign o_m_axis_tdata  = {4'b0000, s_head, s_err, s_steer};

endmodule
`default_nettype wire

/* sv/cls_checker.sv */
// Port-level assertions for the line steering block and their bind.
`default_nettype none
module cls_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_s_axis_tvalid,
    input wire        o_s_axis_tready,
    input wire        o_m_axis_tvalid,
    input wire        i_m_axis_tready,
    input wire [47:0] o_m_axis_tdata,
    input wire        o_cfg_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output item changed while stalled");

    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready == (!o_m_axis_tvalid || i_m_axis_tready))
        else $error("input ready does not follow the output side");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[43:27]) <= 17'sd46080)
                         && ($signed(o_m_axis_tdata[43:27]) >= -17'sd46080))
        else $error("heading outside of +-180 degrees");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output item right after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid || !i_s_axis_tvalid |-> o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind camera_line_steering cls_checker u_cls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_cfg_ready     (o_cfg_ready)
);
`default_nettype wire
